// ===== hw/rtl/dfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared types and constants of the detector readout frame parser.
// ----------------------------------------------------------------------------
package dfp_pkg;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_LOAD
  } dfp_state_t;

  typedef struct packed {
    logic byte_en;
    logic load;
  } dfp_cmd_t;

  typedef struct packed {
    logic burst;
    logic out_free;
    logic k_last;
  } dfp_sts_t;

  localparam logic [15:0] WORD_HDR_FULL  = 16'hEEEE;
  localparam logic [15:0] WORD_HDR_SHORT = 16'hEE5A;
  localparam logic [7:0]  BYTE_SYNC      = 8'hCA;
  localparam logic [23:0] SYNC_PATTERN   = 24'hCACACA;
  localparam logic [2:0]  CHIP_BAD       = 3'd4;
  localparam logic [2:0]  CHIP_INVALID   = 3'd7;
  localparam logic [2:0]  BOARD_INVALID  = 3'd7;
  localparam logic [7:0]  CHAN_INVALID   = 8'hFF;
  localparam logic [1:0]  HDR_NONE       = 2'd0;
  localparam logic [1:0]  HDR_FULL       = 2'd1;
  localparam logic [1:0]  HDR_SHORT      = 2'd2;
  localparam int          POS_EVENT      = 4;
  localparam int          POS_CHANNEL    = 9;
  localparam int          POS_FIRST      = 10;

endpackage

// ===== hw/rtl/dfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfp_ctrl
// Controller: takes bytes, then sequences the record burst of a channel.
// ----------------------------------------------------------------------------
module dfp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dfp_pkg::dfp_sts_t sts,
  output dfp_pkg::dfp_cmd_t cmd
);
  import dfp_pkg::*;

  dfp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (in_tvalid && sts.out_free && sts.burst) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          state_nxt = sts.k_last ? ST_RUN : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.byte_en = 1'b0;
    cmd.load    = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_tready   = sts.out_free;
        cmd.byte_en = in_tvalid && sts.out_free;
      end
      ST_LOAD: begin
        cmd.load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/dfp_datapath.sv =====
// ----------------------------------------------------------------------------
// dfp_datapath
// Frame state, sample store and output record register.
// ----------------------------------------------------------------------------
module dfp_datapath #(
  parameter int SAMPLES_PER_CHANNEL = 30
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic [7:0]        in_tdata,
  input  logic              in_tuser,
  input  dfp_pkg::dfp_cmd_t cmd,
  output dfp_pkg::dfp_sts_t sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);
  import dfp_pkg::*;

  localparam int N   = SAMPLES_PER_CHANNEL;
  localparam int IW  = (N > 1) ? $clog2(N) : 1;
  localparam int CW  = $clog2(N + 2);
  localparam int PW  = $clog2(N + 12);
  localparam logic [PW-1:0] P_EVENT = PW'(POS_EVENT);
  localparam logic [PW-1:0] P_CHAN  = PW'(POS_CHANNEL);
  localparam logic [PW-1:0] P_FIRST = PW'(POS_FIRST);
  localparam logic [PW-1:0] P_END   = PW'(POS_FIRST + N);
  localparam logic [PW-1:0] P_LIMIT = PW'(POS_FIRST + N + 1);
  localparam logic [CW-1:0] C_FULL  = CW'(N);
  localparam logic [IW-1:0] K_LAST  = IW'(N - 1);

  logic               sel_r;
  logic               sync_r, sync_nxt;
  logic [23:0]        hist_r, hist_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [7:0]         high_r, high_nxt;
  logic [1:0]         hp_r, hp_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic signed [16:0] ev_r, ev_nxt;
  logic [14:0]        loop_r, loop_nxt;
  logic [3:0]         raw_r, raw_nxt;
  logic [2:0]         board_r, board_nxt;
  logic [2:0]         chip_r, chip_nxt;
  logic [7:0]         chan_r, chan_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [31:0]        total_r, total_nxt;
  logic               empty_rec, burst;
  logic               st_we;
  logic [IW-1:0]      st_addr;
  logic [11:0]        st_data;
  logic [11:0]        mem [N];
  logic [11:0]        rd_data_r;
  logic [IW-1:0]      k_r;
  logic               ov_r;
  logic [31:0]        o_ev_r;
  logic               o_empty_r, o_last_r;
  logic [1:0]         o_board_r, o_chip_r;
  logic [6:0]         o_chan_r;
  logic [4:0]         o_idx_r;
  logic [11:0]        o_val_r;
  logic               out_free;

  always_comb begin
    logic [15:0]        word;
    logic [11:0]        s;
    logic signed [17:0] diff;
    logic               adv;
    sync_nxt  = sync_r;
    hist_nxt  = hist_r;
    phase_nxt = phase_r;
    high_nxt  = high_r;
    hp_nxt    = hp_r;
    pos_nxt   = pos_r;
    ev_nxt    = ev_r;
    loop_nxt  = loop_r;
    raw_nxt   = raw_r;
    board_nxt = board_r;
    chip_nxt  = chip_r;
    chan_nxt  = chan_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    empty_rec = 1'b0;
    burst     = 1'b0;
    st_we     = 1'b0;
    st_addr   = cnt_r[IW-1:0];
    word      = {high_r, in_tdata};
    s         = word[11:0];
    st_data   = s[11] ? ~s : (~s + 12'd1);
    diff      = $signed({2'b00, word}) - $signed({ev_r[16], ev_r});
    adv       = 1'b1;
    if (in_tuser) begin
      sync_nxt  = 1'b0;
      hist_nxt  = '0;
      phase_nxt = '0;
      hp_nxt    = HDR_NONE;
      loop_nxt  = '0;
    end
    if (!sync_nxt) begin
      hist_nxt = {hist_nxt[15:0], in_tdata};
      if (phase_nxt < 2'd3) begin
        phase_nxt = phase_nxt + 2'd1;
      end else if (hist_nxt == SYNC_PATTERN) begin
        sync_nxt  = 1'b1;
        phase_nxt = '0;
      end
    end else if (hp_r == HDR_SHORT || (hp_r == HDR_FULL && phase_r != 2'd0)) begin
      phase_nxt = '0;
      raw_nxt   = in_tdata[3:0];
      chip_nxt  = (in_tdata[3:0] <= 4'd3) ? {1'b0, in_tdata[1:0]} : CHIP_BAD;
      cnt_nxt   = '0;
      hp_nxt    = HDR_NONE;
      pos_nxt   = PW'(1);
    end else if (hp_r == HDR_FULL) begin
      phase_nxt = 2'd1;
    end else if (phase_r == 2'd0) begin
      high_nxt  = in_tdata;
      phase_nxt = 2'd1;
    end else begin
      phase_nxt = '0;
      if (word == WORD_HDR_FULL || word == WORD_HDR_SHORT) begin
        adv = 1'b0;
        if (pos_r == P_CHAN) begin
          empty_rec = 1'b1;
          total_nxt = {{15{ev_r[16]}}, ev_r} + {1'b0, loop_r, 16'h0000};
        end
        board_nxt = BOARD_INVALID;
        chip_nxt  = CHIP_INVALID;
        chan_nxt  = CHAN_INVALID;
        cnt_nxt   = '0;
        hp_nxt    = (word == WORD_HDR_FULL) ? HDR_FULL : HDR_SHORT;
      end else if (pos_r == P_EVENT) begin
        ev_nxt = $signed({1'b0, word});
        if (diff < -18'sd65000 && ev_r > 17'sd65000) begin
          loop_nxt = loop_r + 15'd1;
        end
        total_nxt = {{15{ev_nxt[16]}}, ev_nxt} + {1'b0, loop_nxt, 16'h0000};
      end else if (pos_r == P_CHAN && word[15:8] == 8'h00) begin
        if (!sel_r) begin
          if (raw_r <= 4'd3) begin
            board_nxt = 3'd0;
            chip_nxt  = {1'b0, raw_r[1:0]};
          end else if (raw_r >= 4'd8) begin
            board_nxt = 3'd1;
            chip_nxt  = (raw_r <= 4'd11) ? {1'b0, raw_r[1:0]} : CHIP_BAD;
          end
        end else begin
          if (raw_r <= 4'd3) begin
            board_nxt = 3'd2;
            chip_nxt  = {1'b0, ~raw_r[1], raw_r[0]};
          end else if (raw_r >= 4'd8) begin
            board_nxt = 3'd3;
            if (raw_r <= 4'd11) begin
              chip_nxt = {1'b0, ~raw_r[1], raw_r[0]};
            end
          end else begin
            chip_nxt = CHIP_INVALID;
            adv      = 1'b0;
          end
        end
        if (adv) begin
          chan_nxt = word[7:0];
        end
      end else if (pos_r == P_END) begin
        if (word[15:8] == 8'h00) begin
          chan_nxt = word[7:0];
          pos_nxt  = P_CHAN;
        end else if (word[15:8] == BYTE_SYNC) begin
          pos_nxt = '0;
        end
      end else if (pos_r >= P_FIRST && pos_r < P_END) begin
        if (cnt_r < C_FULL) begin
          st_we = 1'b1;
        end
        if (cnt_r <= C_FULL) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (pos_r == P_END - PW'(1)) begin
          if (chip_r == CHIP_INVALID) begin
            adv = 1'b0;
          end else if (cnt_nxt == C_FULL) begin
            if (board_r > 3'd3 || chip_r > 3'd3 || chan_r > 8'd127) begin
              adv = 1'b0;
            end else begin
              burst   = 1'b1;
              cnt_nxt = '0;
            end
          end else begin
            cnt_nxt = '0;
          end
        end
      end
      if (adv && pos_nxt < P_LIMIT) begin
        pos_nxt = pos_nxt + PW'(1);
      end
    end
  end

  assign out_free     = !ov_r || out_tready;
  assign sts.out_free = out_free;
  assign sts.burst    = burst;
  assign sts.k_last   = (k_r == K_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      sync_r  <= 1'b0;
      hist_r  <= '0;
      phase_r <= '0;
      high_r  <= '0;
      hp_r    <= HDR_NONE;
      pos_r   <= '0;
      ev_r    <= -17'sd1;
      loop_r  <= '0;
      raw_r   <= '0;
      board_r <= BOARD_INVALID;
      chip_r  <= CHIP_INVALID;
      chan_r  <= CHAN_INVALID;
      cnt_r   <= '0;
      total_r <= 32'hFFFF_FFFF;
      k_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        sel_r <= cfg_wdata;
      end
      if (cmd.byte_en) begin
        sync_r  <= sync_nxt;
        hist_r  <= hist_nxt;
        phase_r <= phase_nxt;
        high_r  <= high_nxt;
        hp_r    <= hp_nxt;
        pos_r   <= pos_nxt;
        ev_r    <= ev_nxt;
        loop_r  <= loop_nxt;
        raw_r   <= raw_nxt;
        board_r <= board_nxt;
        chip_r  <= chip_nxt;
        chan_r  <= chan_nxt;
        cnt_r   <= cnt_nxt;
        total_r <= total_nxt;
      end
      if (cmd.byte_en && burst) begin
        k_r <= '0;
      end else if (cmd.load) begin
        k_r <= k_r + IW'(1);
      end
      if ((cmd.byte_en && empty_rec) || cmd.load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_en && st_we) begin
      mem[st_addr] <= st_data;
    end
    rd_data_r <= mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_en && empty_rec) begin
      o_ev_r    <= total_nxt;
      o_empty_r <= 1'b1;
      o_board_r <= '0;
      o_chip_r  <= '0;
      o_chan_r  <= '0;
      o_idx_r   <= '0;
      o_val_r   <= '0;
      o_last_r  <= 1'b1;
    end else if (cmd.load) begin
      o_ev_r    <= total_r;
      o_empty_r <= 1'b0;
      o_board_r <= board_r[1:0];
      o_chip_r  <= chip_r[1:0];
      o_chan_r  <= chan_r[6:0];
      o_idx_r   <= 5'(k_r);
      o_val_r   <= rd_data_r;
      o_last_r  <= (k_r == K_LAST);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_empty_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'h0, o_val_r, o_idx_r, o_chan_r, o_chip_r, o_board_r, o_ev_r};

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(N + 1)) else $error("sample count out of range");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= P_LIMIT) else $error("word position out of range");
  a_burst_k: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_en && burst |=> k_r == '0) else $error("burst did not start at sample zero");

endmodule

// ===== hw/rtl/detector_readout_frame_parser.sv =====
// ----------------------------------------------------------------------------
// detector_readout_frame_parser
// Parses a detector readout byte stream into per-sample records.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while no record burst is running and the output
// register is free. A byte that completes a channel starts a burst of
// SAMPLES_PER_CHANNEL records from the sample store, each a store read then an
// output load; no byte is taken during the burst.
module detector_readout_frame_parser #(
  parameter int SAMPLES_PER_CHANNEL = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // detector_select
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // byte_value
  input  logic        in_tuser,      // stream_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,     // event_number, board_index, chip_index,
                                     // channel_index, sample_index, sample_value
  output logic        out_tuser,     // empty_package
  output logic        out_tlast      // last
);
  import dfp_pkg::*;

  dfp_cmd_t cmd;
  dfp_sts_t sts;

  dfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dfp_datapath #(
    .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/detector_readout_frame_parser_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser checker
// Watches the byte, record and configuration ports, predicts the records
// of every accepted byte, and compares each record transfer field by field.
// ----------------------------------------------------------------------------
module detector_readout_frame_parser_checker #(
  parameter int SAMPLES_PER_CHANNEL = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          errors,
  output int          pending
);
  import dfp_pkg::*;

  localparam int POS_END   = POS_FIRST + SAMPLES_PER_CHANNEL;
  localparam int POS_LIMIT = POS_END + 1;

  typedef struct packed {
    logic [63:0] data;
    logic        empty;
    logic        last;
  } record_t;

  record_t     records_due[$];
  logic        select_q;
  logic        synced;
  logic [23:0] history;
  logic [1:0]  phase;
  logic [7:0]  hi_byte;
  logic [1:0]  hdr_wait;
  int          position;
  int          evt_word;
  logic [14:0] loops;
  logic [3:0]  chip_raw;
  logic [2:0]  board_map;
  logic [2:0]  chip_map;
  logic [7:0]  channel;
  logic [11:0] samples [SAMPLES_PER_CHANNEL];
  int          count;
  logic [31:0] evt_total;

  function automatic logic [31:0] event_sum();
    return 32'(evt_word) + {loops, 16'h0000};
  endfunction

  function automatic record_t make_record(logic empty, logic [1:0] brd, logic [1:0] chp,
                                          logic [6:0] chn, logic [4:0] idx,
                                          logic [11:0] val, logic lst);
    record_t r;
    r.data  = {4'h0, val, idx, chn, chp, brd, evt_total};
    r.empty = empty;
    r.last  = lst;
    return r;
  endfunction

  task automatic queue_record(record_t r);
    records_due = {records_due, r};
  endtask

  task automatic close_header();
    chip_map = (chip_raw <= 3) ? chip_raw[2:0] : CHIP_BAD;
    count    = 0;
    hdr_wait = HDR_NONE;
    position = 1;
  endtask

  function automatic logic map_location();
    logic [1:0] order [4];
    order = '{2'd2, 2'd3, 2'd0, 2'd1};
    if (!select_q) begin
      if (chip_raw <= 3) begin
        board_map = 3'd0;
        chip_map  = chip_raw[2:0];
      end else if (chip_raw >= 8) begin
        board_map = 3'd1;
        chip_map  = (chip_raw <= 11) ? {1'b0, chip_raw[1:0]} : CHIP_BAD;
      end
    end else begin
      if (chip_raw <= 3) begin
        board_map = 3'd2;
        chip_map  = {1'b0, order[chip_raw[1:0]]};
      end else if (chip_raw >= 8) begin
        board_map = 3'd3;
        if (chip_raw <= 11) chip_map = {1'b0, order[chip_raw[1:0]]};
      end else begin
        chip_map = CHIP_INVALID;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic parse_byte(logic [7:0] b, logic restart);
    logic [15:0] w;
    logic [11:0] s;
    int          v;
    int          prev;
    if (restart) begin
      synced   = 1'b0;
      history  = '0;
      phase    = 2'd0;
      hdr_wait = HDR_NONE;
      loops    = '0;
    end
    if (!synced) begin
      history = {history[15:0], b};
      if (phase < 3) phase = phase + 2'd1;
      else if (history == SYNC_PATTERN) begin
        synced = 1'b1;
        phase  = 2'd0;
      end
      return;
    end
    if (hdr_wait == HDR_SHORT) begin
      chip_raw = b[3:0];
      close_header();
      return;
    end
    if (hdr_wait == HDR_FULL) begin
      if (phase == 0) begin
        phase = 2'd1;
        return;
      end
      phase    = 2'd0;
      chip_raw = b[3:0];
      close_header();
      return;
    end
    if (phase == 0) begin
      hi_byte = b;
      phase   = 2'd1;
      return;
    end
    phase = 2'd0;
    w     = {hi_byte, b};
    if (w == WORD_HDR_FULL || w == WORD_HDR_SHORT) begin
      if (position == POS_CHANNEL) begin
        evt_total = event_sum();
        queue_record(make_record(1'b1, '0, '0, '0, '0, '0, 1'b1));
      end
      board_map = BOARD_INVALID;
      chip_map  = CHIP_INVALID;
      channel   = CHAN_INVALID;
      count     = 0;
      hdr_wait  = (w == WORD_HDR_FULL) ? HDR_FULL : HDR_SHORT;
      return;
    end else if (position == POS_EVENT) begin
      prev     = evt_word;
      evt_word = int'(w);
      if ((evt_word - prev < -65000) && prev > 65000) loops = loops + 15'd1;
      evt_total = event_sum();
    end else if (position == POS_CHANNEL && w[15:8] == 8'h00) begin
      if (!map_location()) return;
      channel = w[7:0];
    end else if (position == POS_END) begin
      if (w[15:8] == 8'h00) begin
        channel  = w[7:0];
        position = POS_CHANNEL;
      end else if (w[15:8] == BYTE_SYNC) begin
        position = 0;
      end
    end else if (position >= POS_FIRST && position < POS_END) begin
      s = w[11:0];
      v = (s >= 12'h800) ? int'(s) - 32'hfff : int'(s);
      if (count < SAMPLES_PER_CHANNEL) samples[count] = 12'(-v);
      if (count <= SAMPLES_PER_CHANNEL) count++;
      if (position == POS_END - 1) begin
        if (chip_map == CHIP_INVALID) return;
        if (count == SAMPLES_PER_CHANNEL) begin
          if (board_map > 3 || chip_map > 3 || channel > 127) return;
          for (int k = 0; k < SAMPLES_PER_CHANNEL; k++)
            queue_record(make_record(1'b0, board_map[1:0], chip_map[1:0],
                                     channel[6:0], 5'(k), samples[k],
                                     k == SAMPLES_PER_CHANNEL - 1));
        end
        count = 0;
      end
    end
    if (position < POS_LIMIT) position++;
  endtask

  task automatic compare_record();
    record_t want;
    logic    bad;
    if (records_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected record tdata=%h tuser=%b tlast=%b", $realtime,
                 out_tdata, out_tuser, out_tlast);
      return;
    end
    want = records_due.pop_front();
    bad  = (want.data[31:0] !== out_tdata[31:0]) || (want.data[33:32] !== out_tdata[33:32])
        || (want.data[35:34] !== out_tdata[35:34]) || (want.data[42:36] !== out_tdata[42:36])
        || (want.data[47:43] !== out_tdata[47:43]) || (want.data[59:48] !== out_tdata[59:48])
        || (out_tdata[63:60] !== 4'h0) || (want.empty !== out_tuser)
        || (want.last !== out_tlast);
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display("%0t: record mismatch expected %h/%b/%b actual %h/%b/%b", $realtime,
                 want.data, want.empty, want.last, out_tdata, out_tuser, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      errors    = 0;
      select_q  = 1'b0;
      synced    = 1'b0;
      history   = '0;
      phase     = 2'd0;
      hi_byte   = '0;
      hdr_wait  = HDR_NONE;
      position  = 0;
      evt_word  = -1;
      loops     = '0;
      chip_raw  = '0;
      board_map = BOARD_INVALID;
      chip_map  = CHIP_INVALID;
      channel   = CHAN_INVALID;
      count     = 0;
      evt_total = 32'hffff_ffff;
      records_due.delete();
      pending   = 0;
    end else begin
      if (cfg_we) select_q = cfg_wdata;
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) compare_record();
      pending = records_due.size();
    end
  end

endmodule

// ===== test/detector_readout_frame_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser testbench
// Feeds readout streams of synced frames with random content, broken frames
// and noise under both detector selections, with bursty input and a stalling
// record sink, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module detector_readout_frame_parser_test;
  import dfp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          errors;
  int          pending;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          event_seed = 0;
  int          sink_mode = 0;
  int          sink_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  detector_readout_frame_parser dut (.*);

  detector_readout_frame_parser_checker checker_i (.*);

  always @(posedge clk) begin
    sink_cycles <= sink_cycles + 1;
    if (sink_cycles % 150 == 0) sink_mode <= $urandom_range(0, 2);
    case (sink_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_byte(logic [7:0] b, logic restart = 1'b0);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_word(logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  function automatic logic [15:0] plain_word();
    logic [15:0] w;
    w = 16'($urandom);
    if (w[15:8] == 8'hEE) w[15:8] = 8'h5E;
    return w;
  endfunction

  task automatic send_header(logic [3:0] chip);
    if ($urandom_range(0, 2) != 0) begin
      send_word(WORD_HDR_FULL);
      send_word({8'($urandom), 4'($urandom), chip});
    end else begin
      send_word(WORD_HDR_SHORT);
      send_byte({4'($urandom), chip});
    end
  endtask

  task automatic send_frame();
    int r;
    r = $urandom_range(0, 9);
    send_header(r < 4 ? 4'($urandom_range(0, 3)) :
                r < 8 ? 4'($urandom_range(8, 11)) : 4'($urandom));
    for (int p = 1; p < POS_CHANNEL; p++) begin
      if (p == POS_EVENT) begin
        if ($urandom_range(0, 7) == 0) event_seed = $urandom_range(65001, 65535);
        else event_seed = (event_seed + $urandom_range(1, 400)) & 16'hffff;
        send_word(16'(event_seed));
      end else send_word(plain_word());
    end
    for (int c = 0; c < 3; c++) begin
      if (c == 0) begin
        if ($urandom_range(0, 14) == 0) begin
          send_header(4'($urandom));
          return;
        end
        send_word({8'h00, ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127))});
      end
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 200) == 0) begin
          send_header(4'($urandom));
          return;
        end
        send_word(plain_word());
      end
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_word({8'($urandom_range(1, 201)), 8'($urandom)});
        return;
      end else if (r < 9 && c < 2) begin
        send_word({8'h00, 8'($urandom_range(0, 127))});
      end else begin
        send_word({BYTE_SYNC, 8'($urandom)});
        return;
      end
    end
  endtask

  task automatic send_sync();
    send_byte(8'($urandom), 1'b1);
    repeat (4) send_byte(BYTE_SYNC);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_select(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF);
    repeat (3) send_byte(BYTE_SYNC);
    send_word(WORD_HDR_SHORT);
    send_byte(8'hFF);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_frame();
    for (int phase_i = 0; phase_i < 2; phase_i++) begin
      wait_idle();
      set_select(phase_i[0] ? 1'b0 : 1'b1);
      send_sync();
      for (int n = 0; n < 1 || bytes_sent < 120 * (phase_i + 1) + 140; n++) begin
        if ($urandom_range(0, 5) == 0) send_sync();
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        send_frame();
      end
    end
    wait_idle();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dfp_pkg.sv
hw/rtl/dfp_ctrl.sv
hw/rtl/dfp_datapath.sv
hw/rtl/detector_readout_frame_parser.sv
test/detector_readout_frame_parser_checker.sv
test/detector_readout_frame_parser_test.sv
